// ----- hw/rtl/tlg_pkg.sv -----
// Shared types and constants for the toroidal life grid engine.
package tlg_pkg;

    localparam int REQ_TYPE_W  = 3;
    localparam int ROW_IDX_W   = 6;
    localparam int COL_IDX_W   = 6;
    localparam int ROW_BITS_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int SIZE_CFG_W  = 7;
    localparam int PERIOD_W    = 10;
    localparam int NBR_CNT_W   = 4;

    localparam logic [REQ_TYPE_W-1:0] REQ_TOGGLE = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_PAUSE  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_START  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

    localparam logic [SIZE_CFG_W-1:0] COLS_RESET   = 7'd64;
    localparam logic [SIZE_CFG_W-1:0] ROWS_RESET   = 7'd64;
    localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 10'd100;

    localparam logic [NBR_CNT_W-1:0] NBR_STAY  = 4'd2;
    localparam logic [NBR_CNT_W-1:0] NBR_BIRTH = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_GEN_RUN,
        ST_FINISH
    } state_t;

    // what to do once the wanted row reaches the head of the ring
    typedef enum logic [1:0] {
        OP_TOGGLE,
        OP_READ,
        OP_GEN_PREV,
        OP_GEN_HEAD
    } op_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/tlg_if.sv -----
// Request and response channel interfaces.
interface tlg_req_if import tlg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [COL_IDX_W-1:0]  col_index;

    modport source (output valid, output req_type, output row_index, output col_index,
                    input ready);
    modport sink   (input valid, input req_type, input row_index, input col_index,
                    output ready);
endinterface

interface tlg_rsp_if import tlg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  generation_done;
    logic                  running;

    modport source (output valid, output row_bits, output generation_done, output running,
                    input ready);
    modport sink   (input valid, input row_bits, input generation_done, input running,
                    output ready);
endinterface

// ----- hw/rtl/tlg_row_cell.sv -----
// One row of the grid ring: holds a row, shifts it on, clears or toggles bits.
module tlg_row_cell import tlg_pkg::*; #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cell_ctrl_t   ctrl,
    input  logic [W-1:0] shift_in,
    input  logic [W-1:0] xor_mask,
    output logic [W-1:0] row
);

    logic [W-1:0] row_reg;
    logic [W-1:0] row_next;

    always_comb
    begin
        if (ctrl.clear)
        begin
            row_next = '0;
        end
        else if (ctrl.shift)
        begin
            row_next = shift_in;
        end
        else
        begin
            row_next = row_reg ^ xor_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule

// ----- hw/rtl/tlg_row_rule.sv -----
// Next-generation row from the rows above, at and below, with column wrap.
module tlg_row_rule import tlg_pkg::*; #(
    parameter int MAX_COLS = 64
) (
    input  logic [MAX_COLS-1:0]             up,
    input  logic [MAX_COLS-1:0]             cur,
    input  logic [MAX_COLS-1:0]             dn,
    input  logic [$clog2(MAX_COLS+1)-1:0]   eff_cols,
    input  logic [MAX_COLS-1:0]             col_mask,
    output logic [MAX_COLS-1:0]             next_row
);

    localparam int CIW = $clog2(MAX_COLS);

    logic [CIW-1:0] last_col;

    assign last_col = CIW'(eff_cols - 1'b1);

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col
        logic [2:0]           lf;
        logic [2:0]           rt;
        logic [NBR_CNT_W-1:0] n;
        logic                 live;

        if (c == 0)
        begin : g_left_wrap
            assign lf = {up[last_col], cur[last_col], dn[last_col]};
        end
        else
        begin : g_left
            assign lf = {up[c-1], cur[c-1], dn[c-1]};
        end

        // right neighbor wraps to column 0 at the in-use edge
        assign rt = (32'(c + 1) == 32'(eff_cols))
                  ? {up[0], cur[0], dn[0]}
                  : {up[(c+1) % MAX_COLS], cur[(c+1) % MAX_COLS], dn[(c+1) % MAX_COLS]};

        assign n = NBR_CNT_W'(lf[2]) + NBR_CNT_W'(lf[1]) + NBR_CNT_W'(lf[0])
                 + NBR_CNT_W'(rt[2]) + NBR_CNT_W'(rt[1]) + NBR_CNT_W'(rt[0])
                 + NBR_CNT_W'(up[c]) + NBR_CNT_W'(dn[c]);

        assign live = cur[c] ? (n == NBR_STAY || n == NBR_BIRTH) : (n == NBR_BIRTH);

        assign next_row[c] = live & col_mask[c];
    end

endmodule

// ----- hw/rtl/toroidal_life_grid_engine.sv -----
// Toroidal life grid engine top level: ring of row cells, sequencer and result register.
// The grid lives in a ring of MAX_ROWS row cells that rotate one row per cycle while the
// sequencer seeks or sweeps; the cell at the head is the only one read or toggled, and it
// goes to the rule unit with the row below it. Pause, start, clear, unknown requests and
// ticks that run no generation go straight to the finish state. A toggle or row read first
// rotates the ring until that row reaches the head. A generation rotates to the last in-use
// row and then to row 0, then sweeps the whole ring once through the rule unit. A new
// request is taken while the previous response still waits in the output register. Config
// is to be written by the user only when idle; the block itself does not enforce it.
module toroidal_life_grid_engine import tlg_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tlg_req_if.sink               req,
    tlg_rsp_if.source             rsp
);

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    // configuration
    logic [SIZE_CFG_W-1:0] cols_cfg_reg;
    logic [SIZE_CFG_W-1:0] rows_cfg_reg;
    logic [PERIOD_W-1:0]   period_cfg_reg;

    logic [CCW-1:0]        eff_cols;
    logic [RCW-1:0]        eff_rows;
    logic [PERIOD_W-1:0]   eff_period;
    logic [MAX_COLS-1:0]   col_mask;

    // sequencer
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [RIW-1:0]        head_reg, head_next;
    logic [RIW-1:0]        target_reg, target_next;
    logic [COL_IDX_W-1:0]  col_reg, col_next;
    logic [MAX_COLS-1:0]   prev_reg, prev_next;
    logic [MAX_COLS-1:0]   first_reg, first_next;
    logic                  run_reg, run_next;
    logic [PERIOD_W-1:0]   tick_reg, tick_next;
    logic [MAX_COLS-1:0]   res_bits_reg, res_bits_next;
    logic                  res_done_reg, res_done_next;

    // response register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [ROW_BITS_W-1:0] rsp_bits_reg, rsp_bits_next;
    logic                  rsp_done_reg, rsp_done_next;
    logic                  rsp_run_reg, rsp_run_next;

    // ring
    logic [MAX_COLS-1:0]   rows [MAX_ROWS];
    logic [MAX_COLS-1:0]   tail_in;
    logic [MAX_COLS-1:0]   head_xor;
    logic [MAX_COLS-1:0]   toggle_mask;
    logic [MAX_COLS-1:0]   dn_row;
    logic [MAX_COLS-1:0]   rule_row;
    cell_ctrl_t            cell_ctrl;

    logic                  req_xfer;
    logic                  rsp_free;
    logic                  row_ok;
    logic                  col_ok;
    logic                  at_target;
    logic                  head_in_use;
    logic [RIW-1:0]        head_inc;
    logic [PERIOD_W-1:0]   tick_inc;
    logic                  gen_due;

    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            eff_cols = CCW'(1);
        end
        else if (32'(cols_cfg_reg) > MAX_COLS)
        begin
            eff_cols = CCW'(MAX_COLS);
        end
        else
        begin
            eff_cols = CCW'(cols_cfg_reg);
        end

        if (rows_cfg_reg == '0)
        begin
            eff_rows = RCW'(1);
        end
        else if (32'(rows_cfg_reg) > MAX_ROWS)
        begin
            eff_rows = RCW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = RCW'(rows_cfg_reg);
        end

        eff_period = (period_cfg_reg == '0) ? PERIOD_W'(1) : period_cfg_reg;
    end

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_mask
        assign col_mask[c]    = (32'(c) < 32'(eff_cols));
        assign toggle_mask[c] = (32'(c) == 32'(col_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg   <= COLS_RESET;
            rows_cfg_reg   <= ROWS_RESET;
            period_cfg_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLS:   cols_cfg_reg   <= cfg_data[SIZE_CFG_W-1:0];
                CFG_ROWS:   rows_cfg_reg   <= cfg_data[SIZE_CFG_W-1:0];
                CFG_PERIOD: period_cfg_reg <= cfg_data[PERIOD_W-1:0];
                default:    ;
            endcase
        end
    end

    assign req_xfer    = req.valid && req.ready;
    assign rsp_free    = !rsp_valid_reg || rsp.ready;
    assign row_ok      = (32'(req.row_index) < 32'(eff_rows));
    assign col_ok      = (32'(req.col_index) < 32'(eff_cols));
    assign at_target   = (head_reg == target_reg);
    assign head_in_use = (32'(head_reg) < 32'(eff_rows));
    assign head_inc    = (32'(head_reg) == MAX_ROWS - 1) ? '0 : head_reg + 1'b1;
    assign tick_inc    = (tick_reg < eff_period) ? tick_reg + 1'b1 : tick_reg;
    assign gen_due     = run_reg && (tick_inc >= eff_period);

    // row below the head wraps to the saved row 0 at the last in-use row
    assign dn_row = (32'(head_reg) == 32'(eff_rows) - 1) ? first_reg : rows[1];

    tlg_row_rule #(
        .MAX_COLS (MAX_COLS)
    ) u_rule (
        .up       (prev_reg),
        .cur      (rows[0]),
        .dn       (dn_row),
        .eff_cols (eff_cols),
        .col_mask (col_mask),
        .next_row (rule_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        head_next      = head_reg;
        target_next    = target_reg;
        col_next       = col_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        run_next       = run_reg;
        tick_next      = tick_reg;
        res_bits_next  = res_bits_reg;
        res_done_next  = res_done_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_bits_next  = rsp_bits_reg;
        rsp_done_next  = rsp_done_reg;
        rsp_run_next   = rsp_run_reg;
        cell_ctrl      = '0;
        tail_in        = rows[0];
        head_xor       = '0;
        req.ready      = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req_xfer)
                begin
                    res_bits_next = '0;
                    res_done_next = 1'b0;
                    state_next    = ST_FINISH;
                    case (req.req_type)
                        REQ_TOGGLE:
                        begin
                            if (row_ok && col_ok)
                            begin
                                target_next = RIW'(req.row_index);
                                col_next    = req.col_index;
                                op_next     = OP_TOGGLE;
                                state_next  = ST_SEEK;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cell_ctrl.clear = 1'b1;
                        end
                        REQ_PAUSE:
                        begin
                            run_next = 1'b0;
                        end
                        REQ_START:
                        begin
                            run_next = 1'b1;
                        end
                        REQ_TICK:
                        begin
                            tick_next = tick_inc;
                            if (gen_due)
                            begin
                                tick_next   = '0;
                                target_next = RIW'(eff_rows - 1'b1);
                                op_next     = OP_GEN_PREV;
                                state_next  = ST_SEEK;
                            end
                        end
                        REQ_READ:
                        begin
                            if (row_ok)
                            begin
                                target_next = RIW'(req.row_index);
                                op_next     = OP_READ;
                                state_next  = ST_SEEK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SEEK:
            begin
                if (at_target)
                begin
                    case (op_reg)
                        OP_TOGGLE:
                        begin
                            head_xor   = toggle_mask;
                            state_next = ST_FINISH;
                        end
                        OP_READ:
                        begin
                            res_bits_next = rows[0] & col_mask;
                            state_next    = ST_FINISH;
                        end
                        OP_GEN_PREV:
                        begin
                            // old last row is the upper neighbor of row 0
                            prev_next   = rows[0];
                            target_next = '0;
                            op_next     = OP_GEN_HEAD;
                        end
                        OP_GEN_HEAD:
                        begin
                            first_next = rows[0];
                            state_next = ST_GEN_RUN;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else
                begin
                    cell_ctrl.shift = 1'b1;
                    head_next       = head_inc;
                end
            end

            ST_GEN_RUN:
            begin
                // new row enters at the tail while the old head becomes the upper neighbor
                cell_ctrl.shift = 1'b1;
                tail_in         = head_in_use ? rule_row : '0;
                prev_next       = rows[0];
                head_next       = head_inc;
                if (32'(head_reg) == MAX_ROWS - 1)
                begin
                    res_done_next = 1'b1;
                    state_next    = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_bits_next  = ROW_BITS_W'(res_bits_reg);
                    rsp_done_next  = res_done_reg;
                    rsp_run_next   = run_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_ring
        logic [MAX_COLS-1:0] cell_in;
        logic [MAX_COLS-1:0] cell_xor;

        if (i == MAX_ROWS - 1)
        begin : g_tail
            assign cell_in = tail_in;
        end
        else
        begin : g_link
            assign cell_in = rows[i+1];
        end

        if (i == 0)
        begin : g_head
            assign cell_xor = head_xor;
        end
        else
        begin : g_body
            assign cell_xor = '0;
        end

        tlg_row_cell #(
            .W (MAX_COLS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (cell_in),
            .xor_mask (cell_xor),
            .row      (rows[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            run_reg       <= 1'b0;
            tick_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            run_reg       <= run_next;
            tick_reg      <= tick_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        target_reg   <= target_next;
        col_reg      <= col_next;
        prev_reg     <= prev_next;
        first_reg    <= first_next;
        res_bits_reg <= res_bits_next;
        res_done_reg <= res_done_next;
        rsp_bits_reg <= rsp_bits_next;
        rsp_done_reg <= rsp_done_next;
        rsp_run_reg  <= rsp_run_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.row_bits        = rsp_bits_reg;
    assign rsp.generation_done = rsp_done_reg;
    assign rsp.running         = rsp_run_reg;

endmodule
